[rtl/tlec_pkg.sv]
// Shared constants, configuration and control types for the two-level cache controller.
`timescale 1ns / 1ps
`default_nettype none
package tlec_pkg;

  localparam int FIELD_W = 48;
  localparam int STAMP_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 4;

  localparam int DEF_FIRST_SETS = 64;
  localparam int DEF_FIRST_WAYS = 8;
  localparam int DEF_SECOND_SETS = 256;
  localparam int DEF_SECOND_WAYS = 8;
  localparam int DEF_ADDRESS_BITS = 48;

  // masked set-index widths before reduction to the set count
  localparam int L1_MIDX_W = 7;
  localparam int L2_MIDX_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L1_INDEX_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L1_WAYS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_L1_USE_LRU    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_L2_INDEX_BITS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_L2_WAYS       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_L2_USE_LRU    = 3'd6;

  typedef struct packed {
    logic [3:0] offset_bits;
    logic [2:0] l1_index_bits;
    logic [3:0] l1_ways;
    logic       l1_use_lru;
    logic [3:0] l2_index_bits;
    logic [3:0] l2_ways;
    logic       l2_use_lru;
  } tlec_cfg_t;

  localparam tlec_cfg_t CFG_RESET = '{
    offset_bits:   4'd6,
    l1_index_bits: 3'd6,
    l1_ways:       4'd8,
    l1_use_lru:    1'b1,
    l2_index_bits: 4'd8,
    l2_ways:       4'd8,
    l2_use_lru:    1'b1
  };

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic sel_victim;
    logic rd_main;
    logic look;
    logic pick;
    logic fill;
    logic rd_vic;
    logic vlook;
    logic vwr;
    logic res_load;
  } tlec_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hit1;
    logic moved;
    logic out_free;
  } tlec_sts_t;

endpackage
`default_nettype wire

[rtl/tlec_if.sv]
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface tlec_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [47:0] address;
  modport source (output valid, command, address, input ready);
  modport sink (input valid, command, address, output ready);
endinterface

interface tlec_rsp_if;
  logic        valid;
  logic        ready;
  logic        l1_hit;
  logic        l2_hit;
  logic        memory_read;
  logic        memory_write;
  logic        victim_moved;
  logic [47:0] victim_block;
  modport source (output valid, l1_hit, l2_hit, memory_read, memory_write, victim_moved,
                  victim_block, input ready);
  modport sink (input valid, l1_hit, l2_hit, memory_read, memory_write, victim_moved,
                victim_block, output ready);
endinterface
`default_nettype wire

[rtl/tlec_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tlec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[rtl/tlec_setmod.sv]
// Set index reduction: masked index modulo the set count, two register stages.
`timescale 1ns / 1ps
`default_nettype none
module tlec_setmod #(
  parameter int SETS = 64,
  parameter int XW = 7,
  localparam int IW = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  wire logic          clk,
  input  wire logic [XW-1:0] x,
  output logic      [IW-1:0] idx
);
  localparam int SH = 2 * XW;
  localparam int RW = SH + 1;
  localparam longint RECIP_L = (longint'(1) << SH) / SETS;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
  localparam int SW = $clog2(SETS + 1);
  localparam logic [SW-1:0] SETS_V = SW'(SETS);
  localparam int CW = XW + SW;

  logic [XW-1:0]    x1;
  logic [XW+RW-1:0] p1;
  logic [XW-1:0]    q1;
  logic [CW-1:0]    qs;
  logic [XW-1:0]    r2;
  logic [CW-1:0]    r_ext;
  logic [CW-1:0]    r_fix;

  // quotient estimate is exact or one low, so one correction step suffices
  assign q1 = XW'(p1 >> SH);
  assign qs = CW'(q1) * CW'(SETS_V);

  always_ff @(posedge clk) begin
    x1 <= x;
    p1 <= (XW+RW)'(x) * (XW+RW)'(RECIP);
    r2 <= x1 - XW'(qs);
  end

  assign r_ext = CW'(r2);
  assign r_fix = (r_ext >= CW'(SETS_V)) ? (r_ext - CW'(SETS_V)) : r_ext;
  assign idx = IW'(r_fix);
endmodule
`default_nettype wire

[rtl/tlec_pick.sv]
// Replacement way picker: first invalid way, else the oldest in a compare tree.
`timescale 1ns / 1ps
`default_nettype none
module tlec_pick
  import tlec_pkg::*;
#(
  parameter int WAYS = 8,
  localparam int WI = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    load,
  input  wire logic [WAYS-1:0]         valid,
  input  wire logic [WAYS*STAMP_W-1:0] stamps,
  input  wire logic [WAYS-1:0]         inuse,
  input  wire logic [STAMP_W-1:0]      acc,
  output logic      [WI-1:0]           way
);
  localparam int P = 1 << WI;

  logic [STAMP_W-1:0] age_q [WAYS];
  logic               inv_found_q;
  logic [WI-1:0]      inv_way_q;
  logic               inv_found;
  logic [WI-1:0]      inv_way;
  logic [STAMP_W-1:0] nage [2*P-1];
  logic [WI-1:0]      nway [2*P-1];

  always_comb begin
    inv_found = 1'b0;
    inv_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (inuse[i] && !valid[i]) begin
        inv_found = 1'b1;
        inv_way = WI'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      inv_found_q <= inv_found;
      inv_way_q <= inv_way;
      for (int i = 0; i < WAYS; i++) begin
        age_q[i] <= inuse[i] ? (acc - stamps[i*STAMP_W +: STAMP_W]) : '0;
      end
    end
  end

  // right child wins only on a strictly larger age: lowest way on ties
  always_comb begin
    for (int i = 0; i < P; i++) begin
      nage[P-1+i] = (i < WAYS) ? age_q[i] : '0;
      nway[P-1+i] = WI'(i);
    end
    for (int n = P - 2; n >= 0; n--) begin
      if (nage[2*n+2] > nage[2*n+1]) begin
        nage[n] = nage[2*n+2];
        nway[n] = nway[2*n+2];
      end else begin
        nage[n] = nage[2*n+1];
        nway[n] = nway[2*n+1];
      end
    end
  end

  assign way = inv_found_q ? inv_way_q : nway[0];
endmodule
`default_nettype wire

[rtl/tlec_ctrl.sv]
// Sequencer for one cache access: clear pass, lookup, fill, victim move, result.
`timescale 1ns / 1ps
`default_nettype none
module tlec_ctrl
  import tlec_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire tlec_sts_t sts,
  output tlec_cmd_t      cmd
);
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RA    = 4'd2;
  localparam logic [3:0] S_RB    = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_LOOK  = 4'd5;
  localparam logic [3:0] S_PICK  = 4'd6;
  localparam logic [3:0] S_FILL  = 4'd7;
  localparam logic [3:0] S_VB    = 4'd8;
  localparam logic [3:0] S_VRD   = 4'd9;
  localparam logic [3:0] S_VLOOK = 4'd10;
  localparam logic [3:0] S_VWR   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_RA;
        end
      end
      S_RA: state_next = S_RB;
      S_RB: state_next = S_RD;
      S_RD: begin
        cmd.rd_main = 1'b1;
        state_next = S_LOOK;
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        state_next = S_PICK;
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        state_next = sts.hit1 ? S_FIN : S_FILL;
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        cmd.sel_victim = 1'b1;
        state_next = sts.moved ? S_VB : S_FIN;
      end
      S_VB: begin
        cmd.sel_victim = 1'b1;
        state_next = S_VRD;
      end
      S_VRD: begin
        cmd.rd_vic = 1'b1;
        state_next = S_VLOOK;
      end
      S_VLOOK: begin
        cmd.vlook = 1'b1;
        state_next = S_VWR;
      end
      S_VWR: begin
        cmd.vwr = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/tlec_dp.sv]
// Datapath: tag, valid and stamp stores for both levels, lookup, fill and result register.
`timescale 1ns / 1ps
`default_nettype none
module tlec_dp
  import tlec_pkg::*;
#(
  parameter int FIRST_SETS = DEF_FIRST_SETS,
  parameter int FIRST_WAYS = DEF_FIRST_WAYS,
  parameter int SECOND_SETS = DEF_SECOND_SETS,
  parameter int SECOND_WAYS = DEF_SECOND_WAYS,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tlec_cfg_t          cfg,
  input  wire logic               command,
  input  wire logic [FIELD_W-1:0] address,
  input  wire tlec_cmd_t          cmd,
  output tlec_sts_t               sts,
  tlec_rsp_if.source              rsp
);
  localparam int FSI_W = (FIRST_SETS > 1) ? $clog2(FIRST_SETS) : 1;
  localparam int SSI_W = (SECOND_SETS > 1) ? $clog2(SECOND_SETS) : 1;
  localparam int FWI_W = (FIRST_WAYS > 1) ? $clog2(FIRST_WAYS) : 1;
  localparam int SWI_W = (SECOND_WAYS > 1) ? $clog2(SECOND_WAYS) : 1;
  localparam int CLR_N = (FIRST_SETS > SECOND_SETS) ? FIRST_SETS : SECOND_SETS;
  localparam int CLR_W = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam logic [FIELD_W-1:0] AMASK = (ADDRESS_BITS >= FIELD_W) ? {FIELD_W{1'b1}} :
      FIELD_W'((64'd1 << ADDRESS_BITS) - 64'd1);
  localparam logic [4:0] FW_V = 5'(FIRST_WAYS);
  localparam logic [4:0] SW_V = 5'(SECOND_WAYS);

  logic [FIELD_W-1:0] blk_q;
  logic               is_write_q;
  logic [STAMP_W-1:0] acc;
  logic [CLR_W-1:0]   clr_idx;

  logic [FSI_W-1:0] set1_idx, set1_q;
  logic [SSI_W-1:0] set2_idx, set2_q, vset_q;
  logic [L1_MIDX_W-1:0] m1;
  logic [L2_MIDX_W-1:0] m2;
  logic [FIELD_W-1:0]   m2_src;

  logic [4:0] w1, w2;
  logic [FIRST_WAYS-1:0]  inuse1;
  logic [SECOND_WAYS-1:0] inuse2;

  logic [FIRST_WAYS-1:0]          l1v_q, l1v_wd;
  logic [FIRST_WAYS*STAMP_W-1:0]  l1s_q, l1s_wd;
  logic [FIRST_WAYS*FIELD_W-1:0]  l1b_q, l1b_wd;
  logic [SECOND_WAYS-1:0]         l2v_q, l2v_wd;
  logic [SECOND_WAYS*STAMP_W-1:0] l2s_q, l2s_wd;
  logic [SECOND_WAYS*FIELD_W-1:0] l2b_q, l2b_wd;
  logic l1v_we, l1s_we, l1b_we, l2v_we, l2s_we, l2b_we;
  logic clr_l1, clr_l2;
  logic [FSI_W-1:0] l1_waddr;
  logic [SSI_W-1:0] l2_waddr;

  logic             hit1, hit2;
  logic [FWI_W-1:0] hit1_way;
  logic [SWI_W-1:0] hit2_way;
  logic             hit1_q, hit2_q;
  logic [FWI_W-1:0] hit1_way_q;
  logic [SWI_W-1:0] hit2_way_q;
  logic [FWI_W-1:0] pick1_way, way1_q, st1_way;
  logic [SWI_W-1:0] pick2_way;
  logic               moved_q;
  logic [FIELD_W-1:0] victim_q;
  logic               out_valid;

  // way counts: zero counts as one, clamped to the store
  assign w1 = (cfg.l1_ways == 4'd0) ? 5'd1 : ((5'(cfg.l1_ways) > FW_V) ? FW_V : 5'(cfg.l1_ways));
  assign w2 = (cfg.l2_ways == 4'd0) ? 5'd1 : ((5'(cfg.l2_ways) > SW_V) ? SW_V : 5'(cfg.l2_ways));

  always_comb begin
    for (int i = 0; i < FIRST_WAYS; i++) inuse1[i] = (5'(i) < w1);
    for (int i = 0; i < SECOND_WAYS; i++) inuse2[i] = (5'(i) < w2);
  end

  // set index: low index bits of the block, reduced modulo the set count
  assign m1 = blk_q[L1_MIDX_W-1:0] & ~({L1_MIDX_W{1'b1}} << cfg.l1_index_bits);
  assign m2_src = cmd.sel_victim ? victim_q : blk_q;
  assign m2 = m2_src[L2_MIDX_W-1:0] & ~({L2_MIDX_W{1'b1}} << cfg.l2_index_bits);

  tlec_setmod #(.SETS(FIRST_SETS), .XW(L1_MIDX_W)) u_set1 (
    .clk(clk), .x(m1), .idx(set1_idx)
  );
  tlec_setmod #(.SETS(SECOND_SETS), .XW(L2_MIDX_W)) u_set2 (
    .clk(clk), .x(m2), .idx(set2_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 32'd1;
      clr_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_idx <= clr_idx + 1'b1;
      if (cmd.res_load) begin
        acc <= acc + 32'd1;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      blk_q <= (address & AMASK) >> cfg.offset_bits;
      is_write_q <= command;
      moved_q <= 1'b0;
      victim_q <= '0;
    end
    if (cmd.rd_main) begin
      set1_q <= set1_idx;
      set2_q <= set2_idx;
    end
    if (cmd.rd_vic) vset_q <= set2_idx;
    if (cmd.look) begin
      hit1_q <= hit1;
      hit1_way_q <= hit1_way;
      hit2_q <= hit2;
      hit2_way_q <= hit2_way;
    end
    if (cmd.pick && !hit1_q) begin
      way1_q <= pick1_way;
      moved_q <= l1v_q[pick1_way];
      victim_q <= l1v_q[pick1_way] ? l1b_q[pick1_way*FIELD_W +: FIELD_W] : '0;
    end
    if (cmd.res_load) begin
      rsp.l1_hit <= hit1_q;
      rsp.l2_hit <= !hit1_q && hit2_q;
      rsp.memory_read <= !hit1_q && !hit2_q;
      rsp.memory_write <= is_write_q;
      rsp.victim_moved <= moved_q;
      rsp.victim_block <= victim_q;
    end
  end

  assign rsp.valid = out_valid;

  // lookup on the rows just read; lowest matching way wins
  always_comb begin
    hit1 = 1'b0;
    hit1_way = '0;
    for (int i = FIRST_WAYS - 1; i >= 0; i--) begin
      if (l1v_q[i] && inuse1[i] && l1b_q[i*FIELD_W +: FIELD_W] == blk_q) begin
        hit1 = 1'b1;
        hit1_way = FWI_W'(i);
      end
    end
    hit2 = 1'b0;
    hit2_way = '0;
    for (int i = SECOND_WAYS - 1; i >= 0; i--) begin
      if (l2v_q[i] && inuse2[i] && l2b_q[i*FIELD_W +: FIELD_W] == blk_q) begin
        hit2 = 1'b1;
        hit2_way = SWI_W'(i);
      end
    end
  end

  tlec_pick #(.WAYS(FIRST_WAYS)) u_pick1 (
    .clk(clk), .load(cmd.look), .valid(l1v_q), .stamps(l1s_q), .inuse(inuse1),
    .acc(acc), .way(pick1_way)
  );
  tlec_pick #(.WAYS(SECOND_WAYS)) u_pick2 (
    .clk(clk), .load(cmd.vlook), .valid(l2v_q), .stamps(l2s_q), .inuse(inuse2),
    .acc(acc), .way(pick2_way)
  );

  // store write controls
  assign clr_l1 = cmd.clr_wr && (32'(clr_idx) < FIRST_SETS);
  assign clr_l2 = cmd.clr_wr && (32'(clr_idx) < SECOND_SETS);
  assign st1_way = cmd.fill ? way1_q : hit1_way_q;

  always_comb begin
    l1v_we = clr_l1 || cmd.fill;
    l1s_we = clr_l1 || cmd.fill || (cmd.pick && hit1_q && cfg.l1_use_lru);
    l1b_we = cmd.fill;
    l1_waddr = clr_l1 ? FSI_W'(clr_idx) : set1_q;
    l1v_wd = clr_l1 ? '0 : (l1v_q | (FIRST_WAYS'(1'b1) << way1_q));
    l1s_wd = l1s_q;
    l1s_wd[st1_way*STAMP_W +: STAMP_W] = acc;
    if (clr_l1) l1s_wd = '0;
    l1b_wd = l1b_q;
    l1b_wd[way1_q*FIELD_W +: FIELD_W] = blk_q;

    l2v_we = clr_l2 || (cmd.pick && !hit1_q && hit2_q) || cmd.vwr;
    l2s_we = clr_l2 || cmd.vwr;
    l2b_we = cmd.vwr;
    l2_waddr = clr_l2 ? SSI_W'(clr_idx) : (cmd.vwr ? vset_q : set2_q);
    if (clr_l2) begin
      l2v_wd = '0;
    end else if (cmd.vwr) begin
      l2v_wd = l2v_q | (SECOND_WAYS'(1'b1) << pick2_way);
    end else begin
      l2v_wd = l2v_q & ~(SECOND_WAYS'(1'b1) << hit2_way_q);
    end
    l2s_wd = l2s_q;
    l2s_wd[pick2_way*STAMP_W +: STAMP_W] = acc;
    if (clr_l2) l2s_wd = '0;
    l2b_wd = l2b_q;
    l2b_wd[pick2_way*FIELD_W +: FIELD_W] = victim_q;
  end

  tlec_ram #(.WIDTH(FIRST_WAYS), .DEPTH(FIRST_SETS)) u_l1v (
    .clk(clk), .we(l1v_we), .waddr(l1_waddr), .wdata(l1v_wd),
    .re(cmd.rd_main), .raddr(set1_idx), .rdata(l1v_q)
  );
  tlec_ram #(.WIDTH(FIRST_WAYS*STAMP_W), .DEPTH(FIRST_SETS)) u_l1s (
    .clk(clk), .we(l1s_we), .waddr(l1_waddr), .wdata(l1s_wd),
    .re(cmd.rd_main), .raddr(set1_idx), .rdata(l1s_q)
  );
  tlec_ram #(.WIDTH(FIRST_WAYS*FIELD_W), .DEPTH(FIRST_SETS)) u_l1b (
    .clk(clk), .we(l1b_we), .waddr(l1_waddr), .wdata(l1b_wd),
    .re(cmd.rd_main), .raddr(set1_idx), .rdata(l1b_q)
  );
  tlec_ram #(.WIDTH(SECOND_WAYS), .DEPTH(SECOND_SETS)) u_l2v (
    .clk(clk), .we(l2v_we), .waddr(l2_waddr), .wdata(l2v_wd),
    .re(cmd.rd_main || cmd.rd_vic), .raddr(set2_idx), .rdata(l2v_q)
  );
  tlec_ram #(.WIDTH(SECOND_WAYS*STAMP_W), .DEPTH(SECOND_SETS)) u_l2s (
    .clk(clk), .we(l2s_we), .waddr(l2_waddr), .wdata(l2s_wd),
    .re(cmd.rd_main || cmd.rd_vic), .raddr(set2_idx), .rdata(l2s_q)
  );
  tlec_ram #(.WIDTH(SECOND_WAYS*FIELD_W), .DEPTH(SECOND_SETS)) u_l2b (
    .clk(clk), .we(l2b_we), .waddr(l2_waddr), .wdata(l2b_wd),
    .re(cmd.rd_main || cmd.rd_vic), .raddr(set2_idx), .rdata(l2b_q)
  );

  assign sts.clr_last = (32'(clr_idx) == CLR_N - 1);
  assign sts.hit1 = hit1_q;
  assign sts.moved = moved_q;
  assign sts.out_free = !out_valid || rsp.ready;

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({rsp.l1_hit, rsp.l2_hit, rsp.memory_read}))
    else $error("result must come from exactly one level");
  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.victim_moved) |-> (rsp.victim_block == '0))
    else $error("victim block set without a victim");
  a_hit_no_move: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rsp.l1_hit) |-> !rsp.victim_moved)
    else $error("victim moved on an L1 hit");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> (acc == $past(acc) + 32'd1))
    else $error("access count did not advance with the result");
endmodule
`default_nettype wire

[rtl/two_level_exclusive_cache_controller.sv]
// Top level of the two-level exclusive cache controller.
// Usage:
//   req carries one access (command 0 read / 1 write, 48-bit byte address);
//   it is taken when req.valid and req.ready are both high.
//   rsp returns one result per request: l1_hit, l2_hit, memory_read,
//   memory_write, victim_moved and victim_block, held until rsp.ready.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data
//   while no request is in flight.
// Order: the result is registered after the lookup on an L1 hit, the fill on
//   a miss with a free L1 way, or the L2 write when an L1 victim moves to L2;
//   the next request is taken once it is registered. The set is read from
//   RAM once, reduced by a two-stage index unit; the victim path does so for L2.
// Reset: a clearing pass writes zero valid and stamp rows into every set of
//   both levels; req.ready stays low until the pass ends.
// Stall: a new request is taken while the previous result waits on rsp;
//   that request finishes its work and then holds until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module two_level_exclusive_cache_controller
  import tlec_pkg::*;
#(
  parameter int FIRST_SETS = DEF_FIRST_SETS,
  parameter int FIRST_WAYS = DEF_FIRST_WAYS,
  parameter int SECOND_SETS = DEF_SECOND_SETS,
  parameter int SECOND_WAYS = DEF_SECOND_WAYS,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  tlec_req_if.sink                   req,
  tlec_rsp_if.source                 rsp
);
  tlec_cfg_t cfg;
  tlec_cmd_t cmd;
  tlec_sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_BITS:   cfg.offset_bits <= cfg_data;
        REG_L1_INDEX_BITS: cfg.l1_index_bits <= cfg_data[2:0];
        REG_L1_WAYS:       cfg.l1_ways <= cfg_data;
        REG_L1_USE_LRU:    cfg.l1_use_lru <= cfg_data[0];
        REG_L2_INDEX_BITS: cfg.l2_index_bits <= cfg_data;
        REG_L2_WAYS:       cfg.l2_ways <= cfg_data;
        REG_L2_USE_LRU:    cfg.l2_use_lru <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tlec_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
    .sts(sts), .cmd(cmd)
  );

  tlec_dp #(
    .FIRST_SETS(FIRST_SETS), .FIRST_WAYS(FIRST_WAYS),
    .SECOND_SETS(SECOND_SETS), .SECOND_WAYS(SECOND_WAYS),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .command(req.command), .address(req.address),
    .cmd(cmd), .sts(sts), .rsp(rsp)
  );
endmodule
`default_nettype wire
